// ----- rtl/core/ffra_pkg.sv -----
package ffra_pkg;

  localparam int HOLE_ENTRIES_DEF  = 64;
  localparam int BLOCK_ENTRIES_DEF = 64;
  localparam int REGION_BITS_DEF   = 20;

  // Fixed widths of the stream fields.
  localparam int SizeW = 21;
  localparam int AddrW = 20;

  localparam logic [SizeW-1:0] RESET_REGION = 21'd65536;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SIZE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_SHORT    = 3'd2,
    ST_NO_HOLE  = 3'd3,
    ST_BAD_ADDR = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

endpackage

// ----- rtl/core/ffra_ram.sv -----
module ffra_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/first_fit_region_allocator.sv -----
// First-fit region allocator: one command word in, one result word out.
// Throughput is one command at a time; the scans read one table entry per cycle from
// the hole and block memories, which have a single read port each. After reset the
// init state writes the first hole entry before the first word is taken.
module first_fit_region_allocator #(
  parameter int HOLE_ENTRIES  = ffra_pkg::HOLE_ENTRIES_DEF,
  parameter int BLOCK_ENTRIES = ffra_pkg::BLOCK_ENTRIES_DEF,
  parameter int REGION_BITS   = ffra_pkg::REGION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [ffra_pkg::SizeW-1:0] cfg_wdata_i,  // region_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // req_size [20:0], address [40:21], zero pad
  input  logic [2:0]  s_axis_tuser,   // op [1:0], partial_free [2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_address [19:0], result_size [40:20],
                                      // free_total [61:41], zero pad
  output logic [2:0]  m_axis_tuser    // status
);
  import ffra_pkg::*;

  // Widths: bases hold an offset, lengths hold up to the whole region, and
  // sums and compares are done wide enough for either the fields or the tables.
  localparam int RB  = REGION_BITS;
  localparam int LW  = RB + 1;
  localparam int SW  = ((RB > AddrW) ? RB : AddrW) + 2;
  localparam int HDW = RB + LW;
  localparam int HIW = (HOLE_ENTRIES > 1) ? $clog2(HOLE_ENTRIES) : 1;
  localparam int BIW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int CW  = $clog2(((HOLE_ENTRIES > BLOCK_ENTRIES) ? HOLE_ENTRIES
                                                              : BLOCK_ENTRIES) + 1);
  localparam logic [SW-1:0] CAP = SW'(1) << RB;
  localparam logic [SW-1:0] RST_SZ = (SW'(RESET_REGION) > CAP) ? CAP : SW'(RESET_REGION);

  // Controller states.
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_HIT  = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DWR  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  // What a scan is looking for.
  localparam logic [1:0] M_FIT   = 2'd0;  // first hole large enough
  localparam logic [1:0] M_BLK   = 2'd1;  // block containing the address
  localparam logic [1:0] M_LEFT  = 2'd2;  // hole ending at the freed piece
  localparam logic [1:0] M_RIGHT = 2'd3;  // hole starting at the piece end

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    hc_q, hc_d, bc_q, bc_d;
  logic [LW-1:0]    free_q, free_d;
  logic [SizeW-1:0] region_q;
  logic             out_valid_q, out_valid_d;
  logic             chk_q, chk_d;

  op_e              op_q, op_d;
  logic [SizeW-1:0] req_q, req_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             part_q, part_d;
  logic [1:0]       mode_q, mode_d;
  logic [CW-1:0]    scan_q, scan_d, chk_idx_q, chk_idx_d;
  logic [RB-1:0]    hit_base_q, hit_base_d, pb_q, pb_d;
  logic [LW-1:0]    hit_len_q, hit_len_d, pl_q, pl_d;
  logic [CW-1:0]    hit_idx_q, hit_idx_d, p_q, p_d;
  logic             mv_hole_q, mv_hole_d, mv_ret_q, mv_ret_d;
  logic [CW-1:0]    mv_src_q, mv_src_d, mv_dst_q, mv_dst_d;
  status_e          res_status_q, res_status_d;
  logic [RB-1:0]    res_addr_q, res_addr_d;
  logic [LW-1:0]    res_size_q, res_size_d;
  status_e          out_status_q, out_status_d;
  logic [AddrW-1:0] out_addr_q, out_addr_d;
  logic [SizeW-1:0] out_size_q, out_size_d, out_free_q, out_free_d;

  logic             h_we, b_we;
  logic [HIW-1:0]   h_waddr, h_raddr;
  logic [BIW-1:0]   b_waddr, b_raddr;
  logic [HDW-1:0]   h_wdata, h_rdata, b_wdata, b_rdata, mv_data;

  logic [RB-1:0]    rd_base;
  logic [LW-1:0]    rd_len;
  logic [SW-1:0]    rd_end, scan_n, off, sz, ext_addr, ext_size, ext_free;
  logic [CW-1:0]    lo, hi, last;
  logic [LW-1:0]    pl_new;
  logic             hit, in_acc;

  // Hole table: {base, length} per entry.
  ffra_ram #(.Width(HDW), .Depth(HOLE_ENTRIES)) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Block table: {base, length} per allocated segment.
  ffra_ram #(.Width(HDW), .Depth(BLOCK_ENTRIES)) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // The read port follows the scan counter, except when an entry is moved.
  assign h_raddr = (state_q == S_DRD) ? mv_src_q[HIW-1:0] : scan_q[HIW-1:0];
  assign b_raddr = (state_q == S_DRD) ? mv_src_q[BIW-1:0] : scan_q[BIW-1:0];
  assign mv_data = mv_hole_q ? h_rdata : b_rdata;

  // Entry under test in the scan, taken from the table that the scan reads.
  always_comb begin
    if (mode_q == M_BLK) begin
      rd_base = b_rdata[HDW-1:LW];
      rd_len  = b_rdata[LW-1:0];
      scan_n  = SW'(bc_q);
    end else begin
      rd_base = h_rdata[HDW-1:LW];
      rd_len  = h_rdata[LW-1:0];
      scan_n  = SW'(hc_q);
    end
    rd_end = SW'(rd_base) + SW'(rd_len);
    unique case (mode_q)
      M_FIT:   hit = SW'(rd_len) >= SW'(req_q);
      M_BLK:   hit = (SW'(rd_base) <= SW'(addr_q)) && (SW'(addr_q) < rd_end);
      M_LEFT:  hit = rd_end == SW'(pb_q);
      M_RIGHT: hit = (chk_idx_q != p_q) && (SW'(rd_base) == SW'(pb_q) + SW'(pl_q));
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    hc_d         = hc_q;
    bc_d         = bc_q;
    free_d       = free_q;
    out_valid_d  = out_valid_q;
    chk_d        = chk_q;
    op_d         = op_q;
    req_d        = req_q;
    addr_d       = addr_q;
    part_d       = part_q;
    mode_d       = mode_q;
    scan_d       = scan_q;
    chk_idx_d    = chk_idx_q;
    hit_base_d   = hit_base_q;
    hit_len_d    = hit_len_q;
    hit_idx_d    = hit_idx_q;
    pb_d         = pb_q;
    pl_d         = pl_q;
    p_d          = p_q;
    mv_hole_d    = mv_hole_q;
    mv_ret_d     = mv_ret_q;
    mv_src_d     = mv_src_q;
    mv_dst_d     = mv_dst_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_size_d   = res_size_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_size_d   = out_size_q;
    out_free_d   = out_free_q;
    h_we         = 1'b0;
    h_waddr      = '0;
    h_wdata      = '0;
    b_we         = 1'b0;
    b_waddr      = '0;
    b_wdata      = '0;
    sz           = (SW'(region_q) > CAP) ? CAP : SW'(region_q);
    off          = SW'(addr_q) - SW'(hit_base_q);
    pl_new       = '0;
    lo           = (hit_idx_q < p_q) ? hit_idx_q : p_q;
    hi           = (hit_idx_q < p_q) ? p_q : hit_idx_q;
    last         = hc_q - 1'b1;
    ext_addr     = SW'(res_addr_q);
    ext_size     = SW'(res_size_q);
    ext_free     = SW'(free_q);

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        h_we    = 1'b1;
        h_wdata = {RB'(0), RST_SZ[LW-1:0]};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d         = op_e'(s_axis_tuser[1:0]);
          part_d       = s_axis_tuser[2];
          req_d        = s_axis_tdata[20:0];
          addr_d       = s_axis_tdata[40:21];
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_size_d   = '0;
          scan_d       = '0;
          chk_d        = 1'b0;
          unique case (op_e'(s_axis_tuser[1:0]))
            OP_ALLOC: begin
              if (s_axis_tdata[20:0] == '0) begin
                res_status_d = ST_BAD_SIZE;
                state_d      = S_RES;
              end else if (SW'(s_axis_tdata[20:0]) > SW'(free_q)) begin
                res_status_d = ST_SHORT;
                state_d      = S_RES;
              end else begin
                mode_d  = M_FIT;
                state_d = S_SCAN;
              end
            end
            OP_FREE, OP_SIZE: begin
              mode_d  = M_BLK;
              state_d = S_SCAN;
            end
            OP_CLEAR: begin
              bc_d   = '0;
              free_d = sz[LW-1:0];
              if (sz == '0) begin
                hc_d = '0;
              end else begin
                h_we    = 1'b1;
                h_wdata = {RB'(0), sz[LW-1:0]};
                hc_d    = CW'(1);
              end
              state_d = S_RES;
            end
            default: state_d = S_RES;
          endcase
        end
      end
      S_SCAN: begin
        // One entry is read per cycle; its data is tested the cycle after.
        if (chk_q && hit) begin
          hit_base_d = rd_base;
          hit_len_d  = rd_len;
          hit_idx_d  = chk_idx_q;
          state_d    = S_HIT;
        end else if (SW'(scan_q) < scan_n) begin
          chk_d     = 1'b1;
          chk_idx_d = scan_q;
          scan_d    = scan_q + 1'b1;
        end else begin
          unique case (mode_q)
            M_FIT: begin
              res_status_d = ST_NO_HOLE;
              state_d      = S_RES;
            end
            M_BLK: begin
              res_status_d = ST_BAD_ADDR;
              state_d      = S_RES;
            end
            M_LEFT: begin
              // Nothing to the left: the piece takes the next free slot.
              p_d    = hc_q;
              mode_d = M_RIGHT;
              scan_d = '0;
              chk_d  = 1'b0;
            end
            default: begin
              h_we    = 1'b1;
              h_waddr = p_q[HIW-1:0];
              h_wdata = {pb_q, pl_q};
              if (p_q == hc_q) begin
                hc_d = hc_q + 1'b1;
              end
              state_d = S_RES;
            end
          endcase
        end
      end
      S_HIT: begin
        unique case (mode_q)
          M_FIT: begin
            if (bc_q >= CW'(BLOCK_ENTRIES)) begin
              res_status_d = ST_FULL;
              state_d      = S_RES;
            end else begin
              b_we       = 1'b1;
              b_waddr    = bc_q[BIW-1:0];
              b_wdata    = {hit_base_q, LW'(req_q)};
              bc_d       = bc_q + 1'b1;
              free_d     = free_q - LW'(req_q);
              res_addr_d = hit_base_q;
              if (SW'(hit_len_q) > SW'(req_q)) begin
                h_we    = 1'b1;
                h_waddr = hit_idx_q[HIW-1:0];
                h_wdata = {hit_base_q + RB'(req_q), hit_len_q - LW'(req_q)};
                state_d = S_RES;
              end else begin
                // Hole used up exactly: the last hole moves into its slot.
                hc_d      = hc_q - 1'b1;
                mv_hole_d = 1'b1;
                mv_src_d  = hc_q - 1'b1;
                mv_dst_d  = hit_idx_q;
                mv_ret_d  = 1'b0;
                state_d   = S_DRD;
              end
            end
          end
          M_BLK: begin
            if (op_q == OP_SIZE) begin
              res_size_d = hit_len_q;
              state_d    = S_RES;
            end else if (hc_q >= CW'(HOLE_ENTRIES)) begin
              res_status_d = ST_FULL;
              state_d      = S_RES;
            end else begin
              if (off == '0 || !part_q) begin
                pl_new    = hit_len_q;
                pb_d      = hit_base_q;
                bc_d      = bc_q - 1'b1;
                mv_hole_d = 1'b0;
                mv_src_d  = bc_q - 1'b1;
                mv_dst_d  = hit_idx_q;
                mv_ret_d  = 1'b1;
                state_d   = S_DRD;
              end else begin
                // Tail free: the block keeps its head.
                pl_new  = hit_len_q - LW'(off);
                pb_d    = RB'(addr_q);
                b_we    = 1'b1;
                b_waddr = hit_idx_q[BIW-1:0];
                b_wdata = {hit_base_q, LW'(off)};
                mode_d  = M_LEFT;
                scan_d  = '0;
                chk_d   = 1'b0;
                state_d = S_SCAN;
              end
              pl_d       = pl_new;
              free_d     = free_q + pl_new;
              res_size_d = pl_new;
            end
          end
          M_LEFT: begin
            pb_d    = hit_base_q;
            pl_d    = hit_len_q + pl_q;
            p_d     = hit_idx_q;
            mode_d  = M_RIGHT;
            scan_d  = '0;
            chk_d   = 1'b0;
            state_d = S_SCAN;
          end
          default: begin
            // Merged hole goes to the lower slot, the higher one is removed.
            h_we    = 1'b1;
            h_waddr = lo[HIW-1:0];
            h_wdata = {pb_q, pl_q + hit_len_q};
            state_d = S_RES;
            if (p_q != hc_q) begin
              hc_d = hc_q - 1'b1;
              if (hi != last) begin
                mv_hole_d = 1'b1;
                mv_src_d  = last;
                mv_dst_d  = hi;
                mv_ret_d  = 1'b0;
                state_d   = S_DRD;
              end
            end
          end
        endcase
      end
      S_DRD: begin
        state_d = S_DWR;
      end
      S_DWR: begin
        if (mv_hole_q) begin
          h_we    = 1'b1;
          h_waddr = mv_dst_q[HIW-1:0];
          h_wdata = mv_data;
        end else begin
          b_we    = 1'b1;
          b_waddr = mv_dst_q[BIW-1:0];
          b_wdata = mv_data;
        end
        if (mv_ret_q) begin
          mode_d  = M_LEFT;
          scan_d  = '0;
          chk_d   = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = ext_addr[AddrW-1:0];
          out_size_d   = ext_size[SizeW-1:0];
          out_free_d   = ext_free[SizeW-1:0];
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      hc_q        <= CW'(1);
      bc_q        <= '0;
      free_q      <= RST_SZ[LW-1:0];
      region_q    <= RESET_REGION;
      out_valid_q <= 1'b0;
      chk_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      hc_q        <= hc_d;
      bc_q        <= bc_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      chk_q       <= chk_d;
      if (cfg_we_i) begin
        region_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    addr_q       <= addr_d;
    part_q       <= part_d;
    mode_q       <= mode_d;
    scan_q       <= scan_d;
    chk_idx_q    <= chk_idx_d;
    hit_base_q   <= hit_base_d;
    hit_len_q    <= hit_len_d;
    hit_idx_q    <= hit_idx_d;
    pb_q         <= pb_d;
    pl_q         <= pl_d;
    p_q          <= p_d;
    mv_hole_q    <= mv_hole_d;
    mv_ret_q     <= mv_ret_d;
    mv_src_q     <= mv_src_d;
    mv_dst_q     <= mv_dst_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_size_q   <= res_size_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_size_q   <= out_size_d;
    out_free_q   <= out_free_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_free_q, out_size_q, out_addr_q};

  // The tables never hold more entries than they have room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= CW'(HOLE_ENTRIES)) else $error("hole count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= CW'(BLOCK_ENTRIES)) else $error("block count overflow");

  // Free space never exceeds the largest region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(free_q) <= CAP) else $error("free space above region size");

  // A word taken in starts work, so no second word is taken the cycle after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready) else $error("second word taken while busy");

endmodule

// ----- sim/first_fit_region_allocator_tb.sv -----
`default_nettype none

// Scoreboard for the region allocator. It keeps its own copy of the free-segment
// and allocated-segment tables and works out the result word for every command
// word that the block accepts.
class alloc_scoreboard;

  typedef struct {
    ffra_pkg::status_e     status;
    logic [19:0]           base;
    logic [20:0]           size;
    logic [20:0]           total;
  } alloc_result_t;

  logic [20:0] region_size;
  logic [19:0] hole_base  [64];
  logic [20:0] hole_len   [64];
  logic [19:0] block_base [64];
  logic [20:0] block_len  [64];
  int unsigned hole_count;
  int unsigned block_count;
  logic [20:0] free_bytes;

  alloc_result_t pending_results[$];
  int unsigned   mismatches;
  int unsigned   words_checked;
  int unsigned   status_seen[6];

  function new();
    region_size   = ffra_pkg::RESET_REGION;
    mismatches    = 0;
    words_checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    rebuild_tables();
  endfunction

  function void rebuild_tables();
    logic [20:0] sz;
    sz = (region_size > 21'h100000) ? 21'h100000 : region_size;
    block_count = 0;
    if (sz == 0) begin
      hole_count = 0;
    end else begin
      hole_base[0] = '0;
      hole_len[0]  = sz;
      hole_count   = 1;
    end
    free_bytes = sz;
  endfunction

  function void remove_hole(int unsigned k);
    hole_count--;
    hole_base[k] = hole_base[hole_count];
    hole_len[k]  = hole_len[hole_count];
  endfunction

  function void remove_block(int unsigned k);
    block_count--;
    block_base[k] = block_base[block_count];
    block_len[k]  = block_len[block_count];
  endfunction

  function int unsigned owning_block(logic [19:0] a);
    for (int unsigned i = 0; i < block_count; i++) begin
      if ({2'b0, block_base[i]} <= {2'b0, a} &&
          {2'b0, a} < {2'b0, block_base[i]} + {1'b0, block_len[i]}) return i;
    end
    return block_count;
  endfunction

  function void write_region(logic [20:0] value);
    region_size = value;
  endfunction

  // Work out the result of one accepted command word.
  function void note_command(ffra_pkg::op_e op, logic [20:0] req, logic [19:0] a, bit part);
    alloc_result_t r;
    int unsigned k, p, lo, hi;
    logic [19:0] off, pb;
    logic [20:0] pl;
    r.status = ffra_pkg::ST_OK;
    r.base   = '0;
    r.size   = '0;
    case (op)
      ffra_pkg::OP_ALLOC: begin
        k = hole_count;
        if (req == 0) begin
          r.status = ffra_pkg::ST_BAD_SIZE;
        end else if (req > free_bytes) begin
          r.status = ffra_pkg::ST_SHORT;
        end else begin
          for (int unsigned i = 0; i < hole_count; i++) begin
            if (hole_len[i] >= req) begin
              k = i;
              break;
            end
          end
          if (k == hole_count) begin
            r.status = ffra_pkg::ST_NO_HOLE;
          end else if (block_count >= 64) begin
            r.status = ffra_pkg::ST_FULL;
          end else begin
            r.base = hole_base[k];
            block_base[block_count] = hole_base[k];
            block_len[block_count]  = req;
            block_count++;
            if (hole_len[k] > req) begin
              hole_base[k] = hole_base[k] + req[19:0];
              hole_len[k]  = hole_len[k] - req;
            end else begin
              remove_hole(k);
            end
            free_bytes = free_bytes - req;
          end
        end
      end
      ffra_pkg::OP_FREE: begin
        k = owning_block(a);
        if (k == block_count) begin
          r.status = ffra_pkg::ST_BAD_ADDR;
        end else if (hole_count >= 64) begin
          r.status = ffra_pkg::ST_FULL;
        end else begin
          off = a - block_base[k];
          if (off == 0 || !part) begin
            pb = block_base[k];
            pl = block_len[k];
            remove_block(k);
          end else begin
            pb = a;
            pl = block_len[k] - {1'b0, off};
            block_len[k] = {1'b0, off};
          end
          p = hole_count;
          hole_base[p] = pb;
          hole_len[p]  = pl;
          hole_count++;
          free_bytes = free_bytes + pl;
          r.size = pl;
          // Join with the hole that ends where the freed piece starts.
          for (int unsigned j = 0; j < hole_count; j++) begin
            if (j != p && {2'b0, hole_base[j]} + {1'b0, hole_len[j]} == {2'b0, hole_base[p]})
            begin
              hole_len[j] = hole_len[j] + hole_len[p];
              remove_hole(p);
              p = j;
              break;
            end
          end
          // Then with the hole that starts where it ends.
          for (int unsigned j = 0; j < hole_count; j++) begin
            if (j != p && {2'b0, hole_base[j]} == {2'b0, hole_base[p]} + {1'b0, hole_len[p]})
            begin
              lo = (j < p) ? j : p;
              hi = (j < p) ? p : j;
              pb = hole_base[p];
              pl = hole_len[p] + hole_len[j];
              hole_base[lo] = pb;
              hole_len[lo]  = pl;
              remove_hole(hi);
              break;
            end
          end
        end
      end
      ffra_pkg::OP_SIZE: begin
        k = owning_block(a);
        if (k == block_count) r.status = ffra_pkg::ST_BAD_ADDR;
        else r.size = block_len[k];
      end
      default: rebuild_tables();
    endcase
    r.total = free_bytes;
    pending_results.push_back(r);
  endfunction

  // Compare one accepted result word with the oldest expectation.
  function void check_result(logic [63:0] d, logic [2:0] u);
    alloc_result_t r;
    if (pending_results.size() == 0) begin
      $error("result word arrived with nothing expected: tdata=%h tuser=%h", d, u);
      mismatches++;
      return;
    end
    r = pending_results.pop_front();
    words_checked++;
    if (u < 6) status_seen[u]++;
    if (u !== r.status) begin
      $error("status: expected %0d, got %0d", r.status, u);
      mismatches++;
    end
    if (d[19:0] !== r.base) begin
      $error("result_address: expected %0d, got %0d", r.base, d[19:0]);
      mismatches++;
    end
    if (d[40:20] !== r.size) begin
      $error("result_size: expected %0d, got %0d", r.size, d[40:20]);
      mismatches++;
    end
    if (d[61:41] !== r.total) begin
      $error("free_total: expected %0d, got %0d", r.total, d[61:41]);
      mismatches++;
    end
  endfunction

endclass

module first_fit_region_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffra_pkg::*;

  // Watchdog limit, with a very wide margin over the slowest free.
  localparam int CycleLimit = 3000000;
  // Settling time after the last result before the block is treated as idle.
  localparam int SettleCycles = 300;
  // Length of the long hold-off of the receiver.
  localparam int HoldCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [20:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  alloc_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned hold_cycles = 0;   // remaining cycles of the long hold-off
  bit          hold_trigger = 1'b0;  // toggled by the stimulus to ask for a hold-off
  bit          hold_seen    = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned settings_run = 0;

  first_fit_region_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake must not keep the run going for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver. Every accepted result word goes to the scoreboard. The ready line
  // follows a pattern of its own: long open stretches, choppy stretches, and an
  // occasional long hold-off requested by the stimulus so that the block backs up.
  int unsigned rx_mode_left = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_trigger != hold_seen) begin
      hold_seen     <= hold_trigger;
      hold_cycles   <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(20, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one command word and wait until the block takes it. The sender works in
  // bursts: within a burst the valid stays high from word to word, and between
  // bursts it usually drops for a random number of cycles.
  task automatic send_word(op_e op, logic [20:0] req, logic [19:0] a, bit part);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, a, req};
    s_axis_tuser  <= {part, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, req, a, part);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait until every expected result word has come back, then
  // let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Set a new region size and rebuild the tables with a clear.
  task automatic new_region(logic [20:0] sz);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_region(sz);
    settings_run++;
    send_word(OP_CLEAR, $urandom, $urandom, $urandom);
  endtask

  // An address inside a live block, or the base of one.
  function automatic logic [19:0] live_address(bit at_base);
    int unsigned k;
    if (sb.block_count == 0) return $urandom;
    k = $urandom_range(0, sb.block_count - 1);
    if (at_base || sb.block_len[k] == 1) return sb.block_base[k];
    return sb.block_base[k] + $urandom_range(0, sb.block_len[k] - 1);
  endfunction

  // One random command word. Most are well formed: allocations that fit, frees
  // and size queries on live blocks. The rest are noise with arbitrary fields.
  task automatic random_word();
    int unsigned pick;
    logic [20:0] req;
    logic [20:0] span;
    pick = $urandom_range(0, 99);
    span = (sb.free_bytes > 8) ? sb.free_bytes / 8 : 21'd1;
    if (pick < 45) begin
      if ($urandom_range(0, 3) != 0) req = $urandom_range(1, 64);
      else req = $urandom_range(1, span);
      send_word(OP_ALLOC, req, $urandom, $urandom);
    end else if (pick < 78) begin
      send_word(OP_FREE, $urandom, live_address($urandom_range(0, 2) == 0), $urandom);
    end else if (pick < 88) begin
      send_word(OP_SIZE, $urandom, live_address(1'b0), $urandom);
    end else if (pick < 98) begin
      send_word(op_e'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
    end else begin
      send_word(OP_CLEAR, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block writes its first hole entry in its init state right after reset.
    repeat (4) @(posedge clk_i);

    // Directed part on the reset region of 65536 bytes.
    send_word(OP_ALLOC, 21'd0, 20'hFFFFF, 1'b1);          // zero size is rejected
    send_word(OP_ALLOC, 21'h1FFFFF, 20'd0, 1'b0);         // larger than everything free
    send_word(OP_ALLOC, 21'd100, 20'd0, 1'b0);
    send_word(OP_ALLOC, 21'd65437, 20'd0, 1'b0);          // one byte more than the free total
    send_word(OP_ALLOC, 21'd200, 20'd0, 1'b0);
    send_word(OP_SIZE, 21'd0, 20'd50, 1'b0);
    send_word(OP_SIZE, 21'd0, 20'd110, 1'b1);
    send_word(OP_FREE, 21'd0, 20'd150, 1'b1);             // tail of the second block
    send_word(OP_FREE, 21'd0, 20'd100, 1'b1);             // partial free at the base
    send_word(OP_FREE, 21'd0, 20'hFFFFF, 1'b0);           // address in no block
    send_word(OP_SIZE, 21'd0, 20'hFFFFF, 1'b0);
    send_word(OP_FREE, 21'd0, 20'd0, 1'b0);
    send_word(OP_CLEAR, 21'h1FFFFF, 20'hFFFFF, 1'b1);
    send_word(OP_ALLOC, 21'd65536, 20'd0, 1'b0);          // uses the single hole up exactly
    send_word(OP_FREE, 21'd0, 20'd65535, 1'b0);
    send_word(OP_ALLOC, 21'd30000, 20'd0, 1'b0);
    send_word(OP_ALLOC, 21'd100, 20'd0, 1'b0);
    send_word(OP_ALLOC, 21'd35436, 20'd0, 1'b0);
    send_word(OP_FREE, 21'd0, 20'd0, 1'b0);
    send_word(OP_FREE, 21'd0, 20'd30100, 1'b0);
    send_word(OP_ALLOC, 21'd40000, 20'd0, 1'b0);          // enough in total, no hole fits
    send_word(OP_FREE, 21'd0, 20'd30050, 1'b0);           // joins holes on both sides

    // Fill the block table with small blocks, overflow it, then cut every block
    // so that the hole table overflows as well.
    send_word(OP_CLEAR, 21'd0, 20'd0, 1'b0);
    for (int i = 0; i < 65; i++) send_word(OP_ALLOC, $urandom_range(2, 40), $urandom, $urandom);
    for (int i = 0; i < 66; i++)
      send_word(OP_FREE, $urandom, sb.block_base[i % 64] + 1, 1'b1);
    // Long hold-off while the sender keeps offering words, so that the block backs up.
    hold_trigger <= ~hold_trigger;
    for (int i = 0; i < 20; i++) random_word();
    for (int i = 0; i < 60; i++) random_word();

    new_region(21'd1048576);
    for (int i = 0; i < 150; i++) random_word();
    new_region(21'd1);
    for (int i = 0; i < 60; i++) random_word();
    new_region(21'd300);
    for (int i = 0; i < 120; i++) random_word();
    new_region($urandom_range(1, 1048576));
    for (int i = 0; i < 120; i++) random_word();
    new_region(21'd65536);
    for (int i = 0; i < 100; i++) random_word();

    drain();
    $display("Sent %0d command words over %0d region settings; %0d result words checked.",
             words_sent, settings_run + 1, sb.words_checked);
    $display("Status counts ok/size/short/hole/addr/full: %0d %0d %0d %0d %0d %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
